// File: rtl/acsp_pkg.sv
// Package: transaction types, phase codes and character helpers for the ARGB color parser.
package acsp_pkg;

  typedef struct packed {
    logic [15:0] char_code;
    logic        is_end;
  } in_t;

  typedef struct packed {
    logic        valid_res;
    logic [1:0]  format_kind;
    logic [31:0] argb;
  } out_t;

  typedef enum logic [1:0] {
    FMT_HEX  = 2'd0,
    FMT_HASH = 2'd1,
    FMT_DEC  = 2'd2,
    FMT_NONE = 2'd3
  } fmt_t;

  typedef enum logic [2:0] {
    PH_WS   = 3'd0,
    PH_ZERO = 3'd1,
    PH_HEX  = 3'd2,
    PH_HASH = 3'd3,
    PH_DEC  = 3'd4
  } ph_t;

  typedef enum logic [1:0] {
    DS_SKIP   = 2'd0,
    DS_SIGNED = 2'd1,
    DS_DIGITS = 2'd2
  } ds_t;

  typedef struct packed {
    ds_t        sub;
    logic       neg;
    logic [7:0] cur;
    logic [2:0] cnt;
    logic       stop;
  } dec_state_t;

  typedef struct packed {
    dec_state_t st;
    logic       wr;
    logic [7:0] val;
  } dec_upd_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] v;
  } hex_t;

  localparam logic [15:0] CH_NUL   = 16'h0000;
  localparam logic [15:0] CH_TAB   = 16'h0009;
  localparam logic [15:0] CH_CR    = 16'h000D;
  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_HASH  = 16'h0023;
  localparam logic [15:0] CH_PLUS  = 16'h002B;
  localparam logic [15:0] CH_COMMA = 16'h002C;
  localparam logic [15:0] CH_MINUS = 16'h002D;
  localparam logic [15:0] CH_ZERO  = 16'h0030;
  localparam logic [15:0] CH_NINE  = 16'h0039;
  localparam logic [15:0] CH_A_UP  = 16'h0041;
  localparam logic [15:0] CH_F_UP  = 16'h0046;
  localparam logic [15:0] CH_X_UP  = 16'h0058;
  localparam logic [15:0] CH_A_LO  = 16'h0061;
  localparam logic [15:0] CH_F_LO  = 16'h0066;
  localparam logic [15:0] CH_X_LO  = 16'h0078;

  localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;
  localparam logic [2:0]  DEC_MAX_FIELDS = 3'd4;
  localparam logic [3:0]  HASH_SAT = 4'd9;
  localparam logic [3:0]  HASH_FULL = 4'd8;
  localparam logic [3:0]  HASH_SHORT = 4'd6;

  function automatic hex_t hex_value(logic [15:0] c);
    hex_t h;
    h.ok = 1'b1;
    h.v  = 4'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      h.v = c[3:0];
    end else if ((c >= CH_A_LO && c <= CH_F_LO) || (c >= CH_A_UP && c <= CH_F_UP)) begin
      h.v = 4'(c[3:0] + 4'd9);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic is_blank(logic [15:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [7:0] pair_byte(logic [15:0] a, logic [15:0] b);
    hex_t ha;
    hex_t hb;
    logic [7:0] r;
    ha = hex_value(a);
    hb = hex_value(b);
    r  = 8'd0;
    if (ha.ok) begin
      r = hb.ok ? {ha.v, hb.v} : {4'd0, ha.v};
    end else if (is_blank(a) || a == CH_PLUS) begin
      r = hb.ok ? {4'd0, hb.v} : 8'd0;
    end else if (a == CH_MINUS) begin
      r = hb.ok ? 8'(8'd0 - {4'd0, hb.v}) : 8'd0;
    end
    return r;
  endfunction

  // One step of the %d,%d,... scanner.
  function automatic dec_upd_t dec_char(dec_state_t s, logic [15:0] c);
    dec_upd_t   u;
    logic       dig;
    logic [7:0] d;
    logic [2:0] cnt_inc;
    u.st    = s;
    u.wr    = 1'b0;
    u.val   = s.neg ? 8'(8'd0 - s.cur) : s.cur;
    dig     = (c >= CH_ZERO) && (c <= CH_NINE);
    d       = {4'd0, c[3:0]};
    cnt_inc = 3'(s.cnt + 3'd1);
    unique case (s.sub)
      DS_SKIP: begin
        if (is_blank(c)) begin
          u.st.sub = DS_SKIP;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          u.st.neg = (c == CH_MINUS);
          u.st.sub = DS_SIGNED;
        end else if (dig) begin
          u.st.cur = d;
          u.st.sub = DS_DIGITS;
        end else begin
          u.st.stop = 1'b1;
        end
      end
      DS_SIGNED: begin
        if (dig) begin
          u.st.cur = d;
          u.st.sub = DS_DIGITS;
        end else begin
          u.st.stop = 1'b1;
        end
      end
      DS_DIGITS: begin
        if (dig) begin
          u.st.cur = 8'(8'(s.cur * 8'd10) + d);
        end else begin
          u.wr     = 1'b1;
          u.st.cnt = cnt_inc;
          if (cnt_inc >= DEC_MAX_FIELDS || c != CH_COMMA) begin
            u.st.stop = 1'b1;
          end else begin
            u.st.sub = DS_SKIP;
            u.st.neg = 1'b0;
            u.st.cur = 8'd0;
          end
        end
      end
      default: begin
        u.st.stop = 1'b1;
      end
    endcase
    return u;
  endfunction

endpackage

// File: rtl/argb_color_string_parser_unit.sv
// Top level: character-serial ARGB color string parser with registered result.
// An accepted terminator loads its result into the registered out_data and out_valid.
// Throughput: one character per cycle; the input stalls only while a held result is stalled.
// Character transactions produce no result; state updates in the same cycle they are taken.
// Reset (rst, synchronous) returns the scanner to the leading-whitespace phase and empties
// the result register; the scanner also returns to that phase after every terminator.
module argb_color_string_parser_unit #(
  parameter int CHAR_WIDTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  acsp_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output acsp_pkg::out_t out_data
);
  import acsp_pkg::*;

  ph_t                   phase, phase_next;
  logic [31:0]           hex_accum, hex_accum_next;
  logic                  hex_seen, hex_seen_next;
  logic [3:0]            hash_length, hash_length_next;
  logic [CHAR_WIDTH-1:0] pair_first, pair_first_next;
  logic [31:0]           hash_bytes, hash_bytes_next;
  dec_state_t            dec, dec_next;
  logic                  scan_stopped, scan_stopped_next;
  logic [7:0]            dec_fields [4];
  logic                  field_wr;
  logic [7:0]            field_val;
  out_t                  res;

  logic                  in_acc;
  logic [CHAR_WIDTH-1:0] c;
  logic [15:0]           cw;
  hex_t                  hv;
  dec_upd_t              du;
  dec_upd_t              du_end;
  logic [3:0]            hash_inc;
  logic [7:0]            fin [4];
  logic [2:0]            fin_cnt;

  assign in_stall = out_valid & out_stall;
  assign in_acc   = in_valid & ~in_stall;
  assign c        = in_data.char_code[CHAR_WIDTH-1:0];
  assign cw       = 16'(c);
  assign hv       = hex_value(cw);
  assign du       = dec_char(dec, cw);
  assign du_end   = dec_char(dec, CH_NUL);
  assign hash_inc = 4'(hash_length + 4'd1);

  // Next-state update for character transactions; clear everything on a terminator.
  always_comb begin
    phase_next        = phase;
    hex_accum_next    = hex_accum;
    hex_seen_next     = hex_seen;
    hash_length_next  = hash_length;
    pair_first_next   = pair_first;
    hash_bytes_next   = hash_bytes;
    dec_next          = dec;
    scan_stopped_next = scan_stopped;
    field_wr          = 1'b0;
    field_val         = du.val;
    if (in_acc) begin
      if (in_data.is_end) begin
        phase_next        = PH_WS;
        hex_accum_next    = '0;
        hex_seen_next     = 1'b0;
        hash_length_next  = '0;
        pair_first_next   = '0;
        hash_bytes_next   = '0;
        dec_next          = '{sub: DS_SKIP, neg: 1'b0, cur: 8'd0, cnt: 3'd0, stop: 1'b0};
        scan_stopped_next = 1'b0;
      end else if (!scan_stopped) begin
        unique case (phase)
          PH_WS: begin
            if (cw == CH_NUL) begin
              scan_stopped_next = 1'b1;
            end else if (cw == CH_SPACE || cw == CH_TAB) begin
              phase_next = PH_WS;
            end else if (cw == CH_ZERO) begin
              phase_next   = PH_ZERO;
              dec_next.sub = DS_DIGITS;
              dec_next.cur = 8'd0;
            end else if (cw == CH_HASH) begin
              phase_next = PH_HASH;
            end else begin
              phase_next        = PH_DEC;
              dec_next          = du.st;
              field_wr          = du.wr;
              scan_stopped_next = du.st.stop;
            end
          end
          PH_ZERO: begin
            if (cw == CH_X_LO || cw == CH_X_UP) begin
              phase_next = PH_HEX;
            end else begin
              phase_next        = PH_DEC;
              dec_next          = du.st;
              field_wr          = du.wr;
              scan_stopped_next = du.st.stop;
            end
          end
          PH_HEX: begin
            if (!hv.ok) begin
              scan_stopped_next = 1'b1;
            end else begin
              hex_accum_next = {hex_accum[27:0], hv.v};
              hex_seen_next  = 1'b1;
            end
          end
          PH_HASH: begin
            if (cw == CH_NUL) begin
              scan_stopped_next = 1'b1;
            end else if (hash_length < HASH_SAT) begin
              hash_length_next = hash_inc;
              if (hash_inc <= HASH_FULL) begin
                if (hash_inc[0]) begin
                  pair_first_next = c;
                end else begin
                  hash_bytes_next = {hash_bytes[23:0],
                                     pair_byte(16'(pair_first), cw)};
                end
              end
            end
          end
          PH_DEC: begin
            dec_next          = du.st;
            field_wr          = du.wr;
            scan_stopped_next = du.st.stop;
          end
          default: begin
            scan_stopped_next = 1'b1;
          end
        endcase
      end
    end
  end

  // Close the last decimal field on the terminator.
  always_comb begin
    fin     = dec_fields;
    fin_cnt = dec.cnt;
    if (!scan_stopped && du_end.wr) begin
      fin[dec.cnt[1:0]] = du_end.val;
      fin_cnt           = du_end.st.cnt;
    end
  end

  always_comb begin
    res = '{valid_res: 1'b0, format_kind: FMT_NONE, argb: 32'd0};
    unique case (phase)
      PH_HEX: begin
        if (hex_seen) begin
          res = '{valid_res: 1'b1, format_kind: FMT_HEX, argb: hex_accum};
        end
      end
      PH_HASH: begin
        if (hash_length == HASH_FULL) begin
          res = '{valid_res: 1'b1, format_kind: FMT_HASH, argb: hash_bytes};
        end else if (hash_length == HASH_SHORT) begin
          res = '{valid_res: 1'b1, format_kind: FMT_HASH,
                  argb: ALPHA_OPAQUE | {8'd0, hash_bytes[23:0]}};
        end
      end
      PH_ZERO, PH_DEC: begin
        if (fin_cnt >= DEC_MAX_FIELDS) begin
          res = '{valid_res: 1'b1, format_kind: FMT_DEC,
                  argb: {fin[0], fin[1], fin[2], fin[3]}};
        end else if (fin_cnt == 3'd3) begin
          res = '{valid_res: 1'b1, format_kind: FMT_DEC,
                  argb: ALPHA_OPAQUE | {8'd0, fin[0], fin[1], fin[2]}};
        end
      end
      default: begin
        res = '{valid_res: 1'b0, format_kind: FMT_NONE, argb: 32'd0};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WS;
      hex_accum    <= '0;
      hex_seen     <= 1'b0;
      hash_length  <= '0;
      pair_first   <= '0;
      hash_bytes   <= '0;
      dec          <= '{sub: DS_SKIP, neg: 1'b0, cur: 8'd0, cnt: 3'd0, stop: 1'b0};
      scan_stopped <= 1'b0;
    end else begin
      phase        <= phase_next;
      hex_accum    <= hex_accum_next;
      hex_seen     <= hex_seen_next;
      hash_length  <= hash_length_next;
      pair_first   <= pair_first_next;
      hash_bytes   <= hash_bytes_next;
      dec          <= dec_next;
      scan_stopped <= scan_stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (field_wr) begin
      dec_fields[dec.cnt[1:0]] <= field_val;
    end
  end

  // Result register: load on a terminator, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc && in_data.is_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_data.is_end) begin
      out_data <= res;
    end
  end

`ifndef SYNTHESIS
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.valid_res) |->
      (out_data.argb == 32'd0 && out_data.format_kind == FMT_NONE))
    else $error("failed parse carries a colour or format");

  a_char_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !in_data.is_end && !(out_valid && out_stall)) |=> !out_valid)
    else $error("character transaction produced a result");

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_data.is_end) |=>
      (out_valid && phase == PH_WS && !scan_stopped && hash_length == 4'd0))
    else $error("terminator did not yield a result and restart the scanner");

  a_hash_sat: assert property (@(posedge clk) disable iff (rst)
    hash_length <= HASH_SAT)
    else $error("hash length ran past saturation");
`endif

endmodule
